### rtl/core/bdg_pkg.sv
`default_nettype none

package bdg_pkg;

    // Fixed field and register widths
    localparam int CFG_W      = 16;
    localparam int BUTTON_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // Defaults for the top-level parameters
    localparam int NUM_KEYS_DEF   = 5;
    localparam int TICK_WIDTH_DEF = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK_TICKS = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] STABLE_TICKS_RST       = 16'd10;
    localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST   = 16'd200;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_TICKS_RST = 16'd50;

    typedef enum logic
    {
        REQ_TICK   = 1'b0,
        REQ_CHANGE = 1'b1
    } req_t;

    typedef enum logic [2:0]
    {
        ST_IDLE    = 3'd0,
        ST_PRESSED = 3'd1,
        ST_CLICK   = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_LONG    = 3'd4
    } gesture_state_t;

    typedef enum logic [2:0]
    {
        EV_NONE         = 3'd0,
        EV_CLICK        = 3'd1,
        EV_LONG         = 3'd2,
        EV_DOUBLE       = 3'd3,
        EV_LONG_RELEASE = 3'd4
    } gesture_event_t;

    typedef enum logic [1:0]
    {
        BEEP_NONE   = 2'd0,
        BEEP_SHORT  = 2'd1,
        BEEP_LONG   = 2'd2,
        BEEP_DOUBLE = 2'd3
    } beep_t;

    // What one item reports about its button
    typedef struct packed
    {
        gesture_event_t evt;
        beep_t          beep;
        logic           level;
        gesture_state_t state;
    } key_result_t;

endpackage

`default_nettype wire

### rtl/core/bdg_key_step.sv
`default_nettype none

// Update of one button's state for one item: debounce on a pin change,
// the gesture machine and the hold counter on a tick.
module bdg_key_step
#(
    parameter int TICK_WIDTH = bdg_pkg::TICK_WIDTH_DEF
)
(
    input  wire bdg_pkg::req_t             req_type,
    input  wire logic                      pin_level,
    input  wire bdg_pkg::gesture_state_t   cur_state,
    input  wire logic                      cur_level,
    input  wire logic [TICK_WIDTH-1:0]     cur_hold,
    input  wire logic [bdg_pkg::CFG_W-1:0] stable_ticks,
    input  wire logic [bdg_pkg::CFG_W-1:0] long_press_ticks,
    input  wire logic [bdg_pkg::CFG_W-1:0] double_click_ticks,
    output bdg_pkg::gesture_state_t        next_state,
    output logic                           next_level,
    output logic [TICK_WIDTH-1:0]          next_hold,
    output logic                           flag_we,
    output bdg_pkg::key_result_t           result
);

    import bdg_pkg::*;

    localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

    logic [CMP_W-1:0] hold_ext;
    logic             stable_reached;
    logic             long_reached;
    logic             double_expired;
    logic             is_tick;
    gesture_event_t   evt;
    beep_t            beep;

    assign hold_ext       = CMP_W'(cur_hold);
    assign stable_reached = hold_ext >= CMP_W'(stable_ticks);
    assign long_reached   = hold_ext == CMP_W'(long_press_ticks);
    assign double_expired = hold_ext >= CMP_W'(double_click_ticks);
    assign is_tick        = req_type == REQ_TICK;

    // Next state of the gesture machine
    always_comb
    begin
        next_state = cur_state;
        if (is_tick)
        begin
            unique case (cur_state)
                ST_IDLE:
                begin
                    if (cur_level)
                        next_state = ST_PRESSED;
                end
                ST_PRESSED:
                begin
                    if (!cur_level)
                        next_state = ST_CLICK;
                    else if (long_reached)
                        next_state = ST_LONG;
                end
                ST_CLICK:
                begin
                    if (double_expired)
                        next_state = ST_IDLE;
                    else if (cur_level)
                        next_state = ST_DOUBLE;
                end
                ST_DOUBLE:
                begin
                    if (!cur_level)
                        next_state = ST_IDLE;
                end
                ST_LONG:
                begin
                    if (!cur_level)
                        next_state = ST_IDLE;
                end
                default:
                begin
                    next_state = ST_IDLE;
                end
            endcase
        end
    end

    // Event and beep raised on the transition
    always_comb
    begin
        evt  = EV_NONE;
        beep = BEEP_NONE;
        if (is_tick)
        begin
            unique case (cur_state)
                ST_IDLE:
                begin
                    if (cur_level)
                        beep = BEEP_SHORT;
                end
                ST_PRESSED:
                begin
                    if (!cur_level)
                        evt = EV_CLICK;
                    else if (long_reached)
                    begin
                        evt  = EV_LONG;
                        beep = BEEP_LONG;
                    end
                end
                ST_CLICK:
                begin
                    if (!double_expired && cur_level)
                    begin
                        evt  = EV_DOUBLE;
                        beep = BEEP_DOUBLE;
                    end
                end
                ST_LONG:
                begin
                    if (!cur_level)
                        evt = EV_LONG_RELEASE;
                end
                default:
                begin
                    evt  = EV_NONE;
                    beep = BEEP_NONE;
                end
            endcase
        end
    end

    // Debounce and hold counter
    always_comb
    begin
        next_level = cur_level;
        if (is_tick)
        begin
            next_hold = (cur_hold == {TICK_WIDTH{1'b1}}) ? cur_hold
                                                         : cur_hold + 1'b1;
        end
        else
        begin
            next_hold = '0;
            if (stable_reached)
                next_level = pin_level;
        end
    end

    assign flag_we      = evt != EV_NONE;
    assign result.evt   = evt;
    assign result.beep  = beep;
    assign result.level = next_level;
    assign result.state = next_state;

endmodule

`default_nettype wire

### rtl/core/button_debounce_gesture_fsm.sv
// Pipeline: an accepted input item goes into the input register, then into the result
// register, from which it is offered on the output.
// Throughput: one item per cycle while the output side keeps up, set by the
// read-modify-write of the per-button state between the input and result registers.
// Reset (rst_n low, asynchronous): every button idle, released, no event and a zero
// hold counter; registers back to 10, 200 and 50 ticks; both pipeline stages empty.
`default_nettype none

module button_debounce_gesture_fsm
#(
    parameter int NUM_KEYS   = bdg_pkg::NUM_KEYS_DEF,
    parameter int TICK_WIDTH = bdg_pkg::TICK_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Input items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] button_index, [3] pin_level, [7:4] zero
    input  wire logic [bdg_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  wire logic                          s_axis_tuser,

    // Result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [2:0] button_out, [5:3] gesture_event, [7:6] beep_request,
    // [8] debounced_pressed, [11:9] gesture_state, [15:12] zero
    output logic [bdg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,

    // Configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bdg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bdg_pkg::CFG_W-1:0]     cfg_data
);

    import bdg_pkg::*;

    // Index width for the per-button storage.
    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // Configuration registers. Writes are always taken; an index beyond the
    // three registers is simply dropped.
    logic [CFG_W-1:0] stable_ticks_reg;
    logic [CFG_W-1:0] long_press_ticks_reg;
    logic [CFG_W-1:0] double_click_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_ticks_reg       <= STABLE_TICKS_RST;
            long_press_ticks_reg   <= LONG_PRESS_TICKS_RST;
            double_click_ticks_reg <= DOUBLE_CLICK_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_STABLE_TICKS)
                stable_ticks_reg <= cfg_data;
            if (cfg_index == CFG_LONG_PRESS_TICKS)
                long_press_ticks_reg <= cfg_data;
            if (cfg_index == CFG_DOUBLE_CLICK_TICKS)
                double_click_ticks_reg <= cfg_data;
        end
    end

    // Pipeline control. The result register advances when it is empty or
    // being taken; the input register advances with it, so an item enters
    // every cycle while the output side keeps up.
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_advance;
    logic step_fire;

    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign step_fire     = in_valid_reg && out_advance;
    assign s_axis_tready = !in_valid_reg || out_advance;
    assign m_axis_tvalid = out_valid_reg;

    // Input register
    req_t                in_req_reg;
    logic [BUTTON_W-1:0] in_button_reg;
    logic                in_pin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_req_reg    <= req_t'(s_axis_tuser);
            in_button_reg <= s_axis_tdata[BUTTON_W-1:0];
            in_pin_reg    <= s_axis_tdata[BUTTON_W];
        end
    end

    // Per-button state. The last event is kept for each button, although no
    // result reports it.
    gesture_state_t        state_reg [NUM_KEYS];
    logic                  level_reg [NUM_KEYS];
    gesture_event_t        flag_reg  [NUM_KEYS];
    logic [TICK_WIDTH-1:0] hold_reg  [NUM_KEYS];

    logic [KEY_W-1:0] key;
    logic             key_in_range;

    assign key          = KEY_W'(in_button_reg);
    assign key_in_range = 6'(in_button_reg) < 6'(NUM_KEYS);

    gesture_state_t        next_state;
    logic                  next_level;
    logic [TICK_WIDTH-1:0] next_hold;
    logic                  flag_we;
    key_result_t           step_result;

    bdg_key_step
    #(
        .TICK_WIDTH (TICK_WIDTH)
    )
    u_step
    (
        .req_type           (in_req_reg),
        .pin_level          (in_pin_reg),
        .cur_state          (state_reg[key]),
        .cur_level          (level_reg[key]),
        .cur_hold           (hold_reg[key]),
        .stable_ticks       (stable_ticks_reg),
        .long_press_ticks   (long_press_ticks_reg),
        .double_click_ticks (double_click_ticks_reg),
        .next_state         (next_state),
        .next_level         (next_level),
        .next_hold          (next_hold),
        .flag_we            (flag_we),
        .result             (step_result)
    );

    // Write back only for a button that exists; others leave all state alone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                state_reg[k] <= ST_IDLE;
                level_reg[k] <= 1'b0;
                flag_reg[k]  <= EV_NONE;
                hold_reg[k]  <= '0;
            end
        end
        else if (step_fire && key_in_range)
        begin
            state_reg[key] <= next_state;
            level_reg[key] <= next_level;
            hold_reg[key]  <= next_hold;
            if (flag_we)
                flag_reg[key] <= step_result.evt;
        end
    end

    // Result register. An unknown button reports zeros beside its echo.
    key_result_t         res_next;
    key_result_t         res_reg;
    logic [BUTTON_W-1:0] res_button_reg;

    always_comb
    begin
        if (key_in_range)
            res_next = step_result;
        else
            res_next = '{evt: EV_NONE, beep: BEEP_NONE, level: 1'b0, state: ST_IDLE};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            res_reg        <= res_next;
            res_button_reg <= in_button_reg;
        end
    end

    assign m_axis_tdata = {4'b0000, res_reg.state, res_reg.level, res_reg.beep,
                           res_reg.evt, res_button_reg};

    // A processed item always lands in the result register on the next edge.
    a_step_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    // A long press event comes with the long beep and the long press state.
    a_long_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.evt == EV_LONG) |->
            (res_reg.beep == BEEP_LONG && res_reg.state == ST_LONG))
        else $error("long press event without long beep and state");

    // A click leaves the machine in the click state.
    a_click_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.evt == EV_CLICK) |-> res_reg.state == ST_CLICK)
        else $error("click event outside the click state");

    // An unknown button reports nothing but its echo.
    a_unknown_button: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !(6'(res_button_reg) < 6'(NUM_KEYS))) |->
            (m_axis_tdata[OUT_DATA_W-1:BUTTON_W] == '0))
        else $error("unknown button reported state");

    // A stalled result must not be overwritten by a new item.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !step_fire)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### test/button_debounce_gesture_fsm_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the five-button debounce and gesture detector.
//
// An initial block queues input items phase by phase. A clocked driver offers
// them in bursts, and a clocked monitor compares each result item with the
// oldest prediction. Every item yields exactly one result item. The predictor
// follows the block's rules per button. A pin change item takes its level only
// once the button's hold counter has reached the stable time, and it always
// clears the counter. A tick item runs the gesture machine and then bumps the
// saturating counter.
module button_debounce_gesture_fsm_test;

    import bdg_pkg::*;

    localparam int KEYS      = NUM_KEYS_DEF;
    localparam int LATENCY   = 2;
    localparam int SPAN_MAX  = 250;
    // A run is about a thousand items, and well under two thousand even when
    // the random gestures come out long. At worst each item meets a sender gap
    // between bursts and a receiver that takes one result in three, plus a long
    // hold and the register writes; the limit allows for that several times over.
    localparam int CYCLE_LIMIT = 200_000;
    localparam logic [TICK_WIDTH_DEF-1:0] HOLD_MAX = {TICK_WIDTH_DEF{1'b1}};
    // Index 3 names no register, so the block must ignore a write to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct
    {
        req_t       req;
        logic [2:0] btn;
        logic       pin;
    } key_item_t;

    typedef struct packed
    {
        logic [2:0]     button;
        gesture_event_t evt;
        beep_t          beep;
        logic           level;
        gesture_state_t state;
    } key_report_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_W-1:0]      cfg_data      = '0;

    // The bench's own copy of the per-button state and of the registers.
    gesture_state_t      key_state [KEYS];
    logic                key_level [KEYS];
    gesture_event_t      key_last_event [KEYS];
    logic [CFG_W-1:0]    key_hold [KEYS];
    logic [CFG_W-1:0]    reg_stable;
    logic [CFG_W-1:0]    reg_long;
    logic [CFG_W-1:0]    reg_double;

    key_item_t   pending_items[$];
    key_report_t expected_reports[$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int send_gap      = 0;
    int rx_cycle      = 0;
    int results_taken = 0;
    int hold_left     = 0;
    int next_hold_at  = 600;

    button_debounce_gesture_fsm u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Works out what one accepted item does to its button and what it reports.
    function automatic key_report_t advance_key(req_t req, logic [2:0] btn, logic pin);
        key_report_t rep;
        logic        pressed;
        rep.button = btn;
        rep.evt    = EV_NONE;
        rep.beep   = BEEP_NONE;
        rep.level  = 1'b0;
        rep.state  = ST_IDLE;
        // A button beyond the last one leaves every state alone.
        if (btn >= KEYS)
            return rep;
        if (req == REQ_CHANGE)
        begin
            if (key_hold[btn] >= reg_stable)
                key_level[btn] = pin;
            key_hold[btn] = '0;
        end
        else
        begin
            pressed = key_level[btn];
            case (key_state[btn])
                ST_IDLE:
                begin
                    if (pressed)
                    begin
                        key_state[btn] = ST_PRESSED;
                        rep.beep       = BEEP_SHORT;
                    end
                end
                ST_PRESSED:
                begin
                    if (!pressed)
                    begin
                        key_state[btn] = ST_CLICK;
                        rep.evt        = EV_CLICK;
                    end
                    else if (key_hold[btn] == reg_long)
                    begin
                        // An exact match, so a counter that has run past the
                        // threshold never turns into a long press.
                        key_state[btn] = ST_LONG;
                        rep.beep       = BEEP_LONG;
                        rep.evt        = EV_LONG;
                    end
                end
                ST_CLICK:
                begin
                    if (key_hold[btn] >= reg_double)
                        key_state[btn] = ST_IDLE;
                    else if (pressed)
                    begin
                        key_state[btn] = ST_DOUBLE;
                        rep.beep       = BEEP_DOUBLE;
                        rep.evt        = EV_DOUBLE;
                    end
                end
                ST_DOUBLE:
                begin
                    if (!pressed)
                        key_state[btn] = ST_IDLE;
                end
                ST_LONG:
                begin
                    if (!pressed)
                    begin
                        key_state[btn] = ST_IDLE;
                        rep.evt        = EV_LONG_RELEASE;
                    end
                end
                default:
                begin
                    key_state[btn] = ST_IDLE;
                end
            endcase
            if (rep.evt != EV_NONE)
                key_last_event[btn] = rep.evt;
            // The counter sticks at its maximum instead of wrapping round.
            if (key_hold[btn] != HOLD_MAX)
                key_hold[btn] = key_hold[btn] + 1'b1;
        end
        rep.level = key_level[btn];
        rep.state = key_state[btn];
        return rep;
    endfunction

    // Keeps the random scripts short when a register holds a huge value.
    function automatic int span(logic [CFG_W-1:0] v);
        return (v > SPAN_MAX) ? SPAN_MAX : int'(v);
    endfunction

    task automatic add_item(req_t req, logic [2:0] btn, logic pin);
        key_item_t it;
        it.req = req;
        it.btn = btn;
        it.pin = pin;
        pending_items.push_back(it);
    endtask

    task automatic add_ticks(logic [2:0] btn, int n);
        for (int i = 0; i < n; i++)
            add_item(REQ_TICK, btn, 1'($urandom_range(0, 1)));
    endtask

    // One press, or a press and a second press, with hold times chosen around
    // the thresholds so that both sides of every comparison come up. A bounce
    // sometimes precedes the press.
    task automatic gesture_run(logic [2:0] btn);
        int st;
        int lp;
        int dc;
        st = span(reg_stable);
        lp = span(reg_long);
        dc = span(reg_double);
        add_ticks(btn, st + $urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
            add_item(REQ_CHANGE, btn, 1'b0);
        add_item(REQ_CHANGE, btn, 1'b1);
        case ($urandom_range(0, 2))
            0:
            begin
                add_ticks(btn, $urandom_range(st, st + 3));
            end
            1:
            begin
                add_ticks(btn, $urandom_range((lp > 2) ? lp - 2 : 0, lp + 3));
            end
            default:
            begin
                add_ticks(btn, $urandom_range(0, lp + 3));
            end
        endcase
        add_item(REQ_CHANGE, btn, 1'b0);
        if ($urandom_range(0, 1) != 0)
        begin
            add_ticks(btn, $urandom_range(st, ((st > dc) ? st : dc) + 1));
            add_item(REQ_CHANGE, btn, 1'b1);
            add_ticks(btn, $urandom_range(st, st + 2));
            add_item(REQ_CHANGE, btn, 1'b0);
        end
        add_ticks(btn, $urandom_range(0, dc + 2));
    endtask

    // Mostly well-formed gestures on random buttons, with stray items mixed in.
    // The stray items break sequences and reach the buttons that do not exist.
    task automatic add_random(int target);
        int start;
        start = pending_items.size();
        while (pending_items.size() - start < target)
        begin
            if ($urandom_range(0, 9) < 2)
                add_item(req_t'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
            else
                gesture_run(3'($urandom_range(0, KEYS - 1)));
        end
    endtask

    // Blocks until every queued item has gone in and every result has come out.
    task automatic settle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STABLE_TICKS:       reg_stable = value;
            CFG_LONG_PRESS_TICKS:   reg_long   = value;
            CFG_DOUBLE_CLICK_TICKS: reg_double = value;
            default:                ;
        endcase
    endtask

    task automatic load_registers(logic [CFG_W-1:0] st, logic [CFG_W-1:0] lp,
                                  logic [CFG_W-1:0] dc);
        write_register(CFG_STABLE_TICKS, st);
        write_register(CFG_LONG_PRESS_TICKS, lp);
        write_register(CFG_DOUBLE_CLICK_TICKS, dc);
        // New items are queued away from the rising edge.
        @(negedge clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: predicts each item as it is accepted, then offers the next one
    // unless the current gap between bursts still has cycles to run.
    always @(posedge clk)
    begin
        key_item_t nxt;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_reports.push_back(advance_key(req_t'(s_axis_tuser),
                                                       s_axis_tdata[2:0], s_axis_tdata[3]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0 || pending_items.size() == 0)
                begin
                    if (send_gap != 0)
                        send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    nxt = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_DATA_W - 4){1'b0}}, nxt.pin, nxt.btn};
                    s_axis_tuser  <= nxt.req;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        send_gap   = $urandom_range(0, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: cycles through a steady stretch, light and heavy random stalls
    // and a fixed one-in-three pattern. Every so many results it holds off for
    // a long stretch, which lets the block fill up and push back on its input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                results_taken++;
            rx_cycle++;
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (results_taken >= next_hold_at)
            begin
                hold_left    = 400;
                next_hold_at = next_hold_at + 20000;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 128) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= (rx_cycle % 3 == 0);
                    default: m_axis_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Monitor: each result item is checked against the oldest prediction.
    always @(posedge clk)
    begin
        key_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result item with no item outstanding: tdata %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("button_out", want.button, m_axis_tdata[2:0]);
                check_field("gesture_event", want.evt, m_axis_tdata[5:3]);
                check_field("beep_request", want.beep, m_axis_tdata[7:6]);
                check_field("debounced_pressed", want.level, m_axis_tdata[8]);
                check_field("gesture_state", want.state, m_axis_tdata[11:9]);
                check_field("padding", 0, m_axis_tdata[OUT_DATA_W-1:12]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("button_debounce_gesture_fsm regression: fail");
            $finish;
        end
    end

    initial
    begin
        reg_stable = STABLE_TICKS_RST;
        reg_long   = LONG_PRESS_TICKS_RST;
        reg_double = DOUBLE_CLICK_TICKS_RST;
        for (int k = 0; k < KEYS; k++)
        begin
            key_state[k]      = ST_IDLE;
            key_level[k]      = 1'b0;
            key_last_event[k] = EV_NONE;
            key_hold[k]       = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // At the reset settings: the buttons that do not exist, a press that
        // comes too soon to be accepted, and a tick with the pin bit set.
        add_item(REQ_TICK, 3'd5, 1'b0);
        add_item(REQ_CHANGE, 3'd6, 1'b1);
        add_item(REQ_TICK, 3'd7, 1'b1);
        add_item(REQ_CHANGE, 3'd0, 1'b1);
        add_item(REQ_TICK, 3'd0, 1'b1);
        add_random(100);
        settle();

        // With very short thresholds, a click followed by a double click on
        // one button, then a long press and its release on another.
        load_registers(16'd1, 16'd4, 16'd3);
        add_ticks(3'd1, 1);
        add_item(REQ_CHANGE, 3'd1, 1'b1);
        add_ticks(3'd1, 1);
        add_item(REQ_CHANGE, 3'd1, 1'b0);
        add_ticks(3'd1, 2);
        add_item(REQ_CHANGE, 3'd1, 1'b1);
        add_ticks(3'd1, 1);
        add_item(REQ_CHANGE, 3'd1, 1'b0);
        add_ticks(3'd1, 1);
        add_ticks(3'd2, 1);
        add_item(REQ_CHANGE, 3'd2, 1'b1);
        add_ticks(3'd2, 5);
        add_item(REQ_CHANGE, 3'd2, 1'b0);
        add_ticks(3'd2, 1);
        add_random(100);
        settle();

        load_registers(16'd2, 16'd6, 16'd5);
        add_random(100);
        settle();

        // Every threshold at zero.
        load_registers(16'd0, 16'd0, 16'd0);
        add_random(100);
        settle();

        // Instant debounce, with long press and double click windows that
        // never run out. The write to the unused index must change nothing.
        load_registers(16'd0, 16'hFFFF, 16'hFFFF);
        write_register(CFG_UNUSED, 16'hFFFF);
        @(negedge clk);
        add_random(40);
        settle();

        load_registers(16'd3, 16'd9, 16'd2);
        add_random(100);
        settle();

        // The longest stable time refuses presses that follow only a short
        // run of ticks, so the buttons stay released.
        load_registers(16'hFFFF, 16'hFFFF, 16'd0);
        add_ticks(3'd0, 3);
        add_item(REQ_CHANGE, 3'd0, 1'b1);
        add_ticks(3'd4, 20);
        add_item(REQ_CHANGE, 3'd4, 1'b1);
        add_ticks(3'd4, 2);
        settle();

        if (mismatches == 0)
            $display("button_debounce_gesture_fsm regression: pass");
        else
            $display("button_debounce_gesture_fsm regression: fail");
        $finish;
    end

endmodule

### sim.f
rtl/core/bdg_pkg.sv
rtl/core/bdg_key_step.sv
rtl/core/button_debounce_gesture_fsm.sv
test/button_debounce_gesture_fsm_test.sv
